### src/normalized_gray_histogram_core_macros.svh
// Assertion macros shared by the histogram checker.
`ifndef NORMALIZED_GRAY_HISTOGRAM_CORE_MACROS_SVH
`define NORMALIZED_GRAY_HISTOGRAM_CORE_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define NGH_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while reset is asserted.
`define NGH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define NGH_ASSERT_RESET_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### src/ngh_pkg.sv
// Shared constants, codes and types of the normalized gray histogram.
`timescale 1ns / 1ps

package ngh_pkg;

  localparam int BIN_COUNT     = 256;
  localparam int COUNT_W       = 32;
  localparam int SAMPLE_W      = 16;
  localparam int RESERVED_BINS = 3;
  localparam int SCALE_W       = 24;
  localparam int SCALE_FRAC    = 16;
  localparam int SEL_W         = 8;
  localparam int OUT_COUNT_W   = 32;
  localparam int DATA_W        = 32;
  localparam int CFG_ADDR_W    = 4;
  localparam int BIN_W         = $clog2(BIN_COUNT);
  localparam int DIFF_W        = SAMPLE_W + 1;
  localparam int PROD_W        = SAMPLE_W + SCALE_W;
  localparam int Q_DEPTH       = 4;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);

  // Command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_COUNT = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_RANGE_MIN = 2'd0;
  localparam logic [1:0] REG_BIN_SCALE = 2'd1;
  localparam logic [1:0] REG_COUNT_EN  = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] RANGE_MIN_RST = '0;
  localparam logic [SCALE_W-1:0]         BIN_SCALE_RST = SCALE_W'(65536);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] range_min;
    logic [SCALE_W-1:0]         scale;
    logic                       enable;
  } ngh_cfg_t;

  // One operation for the back end
  typedef struct packed {
    logic [1:0]       op;
    logic [BIN_W-1:0] addr;
    logic             zero;
  } ngh_op_t;

  typedef struct packed {
    logic    vld;
    ngh_op_t op;
  } ngh_push_t;

endpackage

### src/normalized_gray_histogram_core.sv
// Top level of the normalized gray histogram: register port, front end, queue, back end.
`timescale 1ns / 1ps

// Each accepted command passes two front-end stages (difference, then the
// 16x24 scale multiply and bin saturation) and waits in a four-entry queue
// for the back end. In the back end a clear needs no finish state (valid bits
// drop at once, so no clearing pass is needed after reset or a clear); a count
// or a read first reads the bin from the single-port bin memory, then writes the
// incremented count or launches the result, and no new item leaves the queue
// before that is done. busy rises only when the queue and the front stages
// together hold four items. A read result appears on out_valid for exactly one
// cycle, after the read has passed the front-end stages, the queue, the bin read
// and the result register; results cannot be held off by the receiver. Bins 0
// to 2 always read as zero. Write the registers only while the block is idle.
module normalized_gray_histogram_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_command,
  input  logic signed [ngh_pkg::SAMPLE_W-1:0]  in_sample_value,
  input  logic [ngh_pkg::SEL_W-1:0]            in_bin_select,
  output logic                                 out_valid,
  output logic [ngh_pkg::OUT_COUNT_W-1:0]      out_bin_count,
  output logic [ngh_pkg::SEL_W-1:0]            out_bin_index,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ngh_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [ngh_pkg::DATA_W-1:0]           pwdata,
  output logic [ngh_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready
);
  import ngh_pkg::*;

  logic signed [SAMPLE_W-1:0] cfg_min_r;
  logic [SCALE_W-1:0]         cfg_scale_r;
  logic                       cfg_en_r;
  logic                       cfg_wr;
  logic [1:0]                 cfg_idx;
  ngh_cfg_t                   cfg;

  ngh_push_t                  push;
  ngh_op_t                    head;
  logic                       empty;
  logic                       pop;
  logic [Q_PTR_W:0]           q_count;
  logic [1:0]                 occupancy;
  logic [Q_PTR_W+1:0]         credit;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_min_r   <= RANGE_MIN_RST;
      cfg_scale_r <= BIN_SCALE_RST;
      cfg_en_r    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RANGE_MIN: cfg_min_r   <= pwdata[SAMPLE_W-1:0];
        REG_BIN_SCALE: cfg_scale_r <= pwdata[SCALE_W-1:0];
        REG_COUNT_EN:  cfg_en_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_RANGE_MIN: prdata = DATA_W'($unsigned(cfg_min_r));
      REG_BIN_SCALE: prdata = DATA_W'(cfg_scale_r);
      REG_COUNT_EN:  prdata = DATA_W'(cfg_en_r);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    cfg.range_min = cfg_min_r;
    cfg.scale     = cfg_scale_r;
    cfg.enable    = cfg_en_r;
  end

  // Hold input while queued plus in-flight items could fill the queue
  assign credit = (Q_PTR_W+2)'(q_count) + (Q_PTR_W+2)'(occupancy);
  assign busy   = (credit >= (Q_PTR_W+2)'(Q_DEPTH));

  ngh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (start && !busy),
    .command   (in_command),
    .sample    (in_sample_value),
    .sel       (in_bin_select),
    .cfg       (cfg),
    .push      (push),
    .occupancy (occupancy)
  );

  ngh_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .count (q_count)
  );

  ngh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_count (out_bin_count),
    .out_index (out_bin_index)
  );

endmodule

### src/ngh_fifo.sv
// Short operation queue between the front end and the back end.
`timescale 1ns / 1ps

module ngh_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ngh_pkg::ngh_push_t         push,
  input  logic                       pop,
  output ngh_pkg::ngh_op_t           head,
  output logic                       empty,
  output logic [ngh_pkg::Q_PTR_W:0]  count
);
  import ngh_pkg::*;

  ngh_op_t              q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]     count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push.vld ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (Q_PTR_W+1)'(push.vld) - (Q_PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Room is guaranteed by the credit check on the input side
  always_ff @(posedge clk) begin
    if (push.vld) begin
      q_mem_r[wr_ptr_r] <= push.op;
    end
  end

  assign head  = q_mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

### src/ngh_front.sv
// Front end: filters commands and maps sample values to bins in two stages.
`timescale 1ns / 1ps

module ngh_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [1:0]                        command,
  input  logic signed [ngh_pkg::SAMPLE_W-1:0] sample,
  input  logic [ngh_pkg::SEL_W-1:0]         sel,
  input  ngh_pkg::ngh_cfg_t                 cfg,
  output ngh_pkg::ngh_push_t                push,
  output logic [1:0]                        occupancy
);
  import ngh_pkg::*;

  localparam int BIN_RAW_W = PROD_W - SCALE_FRAC;
  localparam logic [BIN_RAW_W-1:0] BIN_LAST = BIN_RAW_W'(BIN_COUNT - 1);

  logic signed [DIFF_W-1:0] diff;
  logic                     keep;

  logic                a_vld_r;
  logic [1:0]          a_op_r;
  logic                a_pos_r;
  logic [SAMPLE_W-1:0] a_mag_r;
  logic [SEL_W-1:0]    a_sel_r;

  logic                b_vld_r;
  logic [1:0]          b_op_r;
  logic                b_pos_r;
  logic [PROD_W-1:0]   b_prod_r;
  logic [SEL_W-1:0]    b_sel_r;

  logic [BIN_RAW_W-1:0] bin_raw;
  logic [BIN_W-1:0]     bin;
  logic                 sel_zero;

  assign diff = DIFF_W'(sample) - DIFF_W'(cfg.range_min);

  // Drop unused codes and samples while counting is off
  always_comb begin
    keep = 1'b0;
    unique case (command)
      CMD_CLEAR: keep = 1'b1;
      CMD_COUNT: keep = cfg.enable;
      CMD_READ:  keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept && keep;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_op_r   <= command;
    a_pos_r  <= !diff[DIFF_W-1] && (diff != '0);
    a_mag_r  <= diff[SAMPLE_W-1:0];
    a_sel_r  <= sel;
    b_op_r   <= a_op_r;
    b_pos_r  <= a_pos_r;
    b_prod_r <= PROD_W'(a_mag_r) * PROD_W'(cfg.scale);
    b_sel_r  <= a_sel_r;
  end

  assign bin_raw  = b_prod_r[PROD_W-1:SCALE_FRAC];
  assign sel_zero = (int'(b_sel_r) < RESERVED_BINS) || (int'(b_sel_r) >= BIN_COUNT);

  always_comb begin
    if (!b_pos_r) begin
      bin = '0;
    end else if (bin_raw > BIN_LAST) begin
      bin = BIN_LAST[BIN_W-1:0];
    end else begin
      bin = bin_raw[BIN_W-1:0];
    end
  end

  always_comb begin
    push.vld     = b_vld_r;
    push.op.op   = b_op_r;
    push.op.addr = (b_op_r == CMD_READ) ? BIN_W'(b_sel_r) : bin;
    push.op.zero = (b_op_r == CMD_READ) && sel_zero;
  end

  assign occupancy = 2'(a_vld_r) + 2'(b_vld_r);

endmodule

### src/ngh_back.sv
// Back end: bin memory with valid bits, read-modify-write and read results.
`timescale 1ns / 1ps

module ngh_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ngh_pkg::ngh_op_t                 head,
  input  logic                             empty,
  output logic                             pop,
  output logic                             out_valid,
  output logic [ngh_pkg::OUT_COUNT_W-1:0]  out_count,
  output logic [ngh_pkg::SEL_W-1:0]        out_index
);
  import ngh_pkg::*;

  localparam logic BK_IDLE   = 1'b0;
  localparam logic BK_FINISH = 1'b1;

  logic                   state_r, state_nxt;
  ngh_op_t                cur_r;
  logic [COUNT_W-1:0]     bin_mem_r [BIN_COUNT];
  logic [COUNT_W-1:0]     rd_data_r;
  logic                   rd_vld_r;
  logic [BIN_COUNT-1:0]   valid_r;

  logic                   clr;
  logic                   mem_re;
  logic                   mem_we;
  logic [COUNT_W-1:0]     cnt;
  logic [COUNT_W-1:0]     inc;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_COUNT_W-1:0] out_count_r;
  logic [SEL_W-1:0]       out_index_r;

  assign pop    = (state_r == BK_IDLE) && !empty;
  assign clr    = pop && (head.op == CMD_CLEAR);
  assign mem_re = pop && (head.op != CMD_CLEAR);

  // A bin never written since the last clear reads as zero
  assign cnt = rd_vld_r ? rd_data_r : '0;
  assign inc = (cnt == '1) ? cnt : cnt + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    mem_we        = 1'b0;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (mem_re) begin
          state_nxt = BK_FINISH;
        end
      end
      BK_FINISH: begin
        state_nxt = BK_IDLE;
        unique case (cur_r.op)
          CMD_COUNT: mem_we = 1'b1;
          CMD_READ:  out_valid_nxt = 1'b1;
          default: ;
        endcase
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr) begin
        valid_r <= '0;
      end else if (mem_we) begin
        valid_r[cur_r.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem_r[cur_r.addr] <= inc;
    end
    if (mem_re) begin
      rd_data_r <= bin_mem_r[head.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      cur_r    <= head;
      rd_vld_r <= valid_r[head.addr];
    end
    if (out_valid_nxt) begin
      out_count_r <= cur_r.zero ? '0 : OUT_COUNT_W'(cnt);
      out_index_r <= SEL_W'(cur_r.addr);
    end
  end

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;
  assign out_index = out_index_r;

endmodule

### src/ngh_checker.sv
// Port-level checker for the histogram core and its bind.
`timescale 1ns / 1ps
`include "normalized_gray_histogram_core_macros.svh"

module ngh_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 busy,
  input logic                                 out_valid,
  input logic [ngh_pkg::OUT_COUNT_W-1:0]      out_bin_count,
  input logic [ngh_pkg::SEL_W-1:0]            out_bin_index,
  input logic                                 psel,
  input logic                                 pready
);
  import ngh_pkg::*;

  // Reserved bins always report an empty count
  `NGH_ASSERT_IMPLY(a_reserved_zero, out_valid && (out_bin_index < SEL_W'(RESERVED_BINS)), out_bin_count == '0, "reserved bin read nonzero")

  // The back end returns to its idle state after each read result, so strobes never touch
  `NGH_ASSERT_NEXT(a_strobe_gap, out_valid, !out_valid, "result strobes back to back")

  // After reset the block is free and does not raise a result strobe at once
  `NGH_ASSERT_RESET_NEXT(a_reset_quiet, !rst_n, (!busy && !out_valid) ##1 !out_valid ##1 !out_valid, "activity right after reset")

  `NGH_ASSERT_IMPLY(a_pready_high, psel, pready, "register port stalled")

endmodule

bind normalized_gray_histogram_core ngh_checker u_ngh_checker (.*);

### tb/tb_normalized_gray_histogram_core.sv
// Self-checking testbench for the normalized gray histogram core.
`timescale 1ns / 1ps

module tb_normalized_gray_histogram_core;
  import ngh_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam int SEGMENT_ITEMS = 128;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] count;
    logic [SEL_W-1:0]       index;
  } bin_read_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 in_command = CMD_CLEAR;
  logic signed [SAMPLE_W-1:0] in_sample_value = '0;
  logic [SEL_W-1:0]           in_bin_select = '0;
  logic                       out_valid;
  logic [OUT_COUNT_W-1:0]     out_bin_count;
  logic [SEL_W-1:0]           out_bin_index;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]          pwdata = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  // Predicted histogram state and register copy
  logic signed [SAMPLE_W-1:0] model_min = RANGE_MIN_RST;
  logic [SCALE_W-1:0]         model_scale = BIN_SCALE_RST;
  logic                       model_enable = 1'b0;
  logic [COUNT_W-1:0]         model_bins [BIN_COUNT];
  bin_read_t                  pending_reads [$];

  int idle_pct = 0;
  int fail_count = 0;
  int items_sent = 0;
  int reads_checked = 0;
  int cfg_writes = 0;
  int stall_cycles = 0;

  normalized_gray_histogram_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_sample_value (in_sample_value),
    .in_bin_select   (in_bin_select),
    .out_valid       (out_valid),
    .out_bin_count   (out_bin_count),
    .out_bin_index   (out_bin_index),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t mismatch: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    end
  endtask

  function automatic void clear_model_bins();
    foreach (model_bins[i]) model_bins[i] = '0;
  endfunction

  // Bin of a sample: floor((value - min) * scale / 2^16), saturated to 0..255.
  function automatic int bin_for_sample(input logic signed [SAMPLE_W-1:0] value);
    longint diff;
    longint prod;
    diff = longint'(value) - longint'(model_min);
    if (diff <= 0) return 0;
    prod = diff * longint'(model_scale);
    prod = prod >>> SCALE_FRAC;
    if (prod > BIN_COUNT - 1) return BIN_COUNT - 1;
    return int'(prod);
  endfunction

  task automatic update_histogram_model(input logic [1:0] cmd,
                                        input logic signed [SAMPLE_W-1:0] value,
                                        input logic [SEL_W-1:0] sel);
    int        b;
    bin_read_t rd;
    case (cmd)
      CMD_CLEAR: begin
        clear_model_bins();
      end
      CMD_COUNT: begin
        if (model_enable) begin
          b = bin_for_sample(value);
          if (model_bins[b] != '1) model_bins[b] = model_bins[b] + 1'b1;
        end
      end
      CMD_READ: begin
        rd.index = sel;
        rd.count = (sel >= RESERVED_BINS) ? OUT_COUNT_W'(model_bins[sel]) : '0;
        pending_reads.push_back(rd);
      end
      default: ;
    endcase
  endtask

  // Drive one command item and hold it until the core takes it.
  task automatic issue_command(input logic [1:0] cmd, input int value, input int sel);
    // Idle cycle by cycle so the idle share of sender cycles matches idle_pct
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start           <= 1'b1;
    in_command      <= cmd;
    in_sample_value <= SAMPLE_W'(value);
    in_bin_select   <= SEL_W'(sel);
    do @(posedge clk); while (busy);
    items_sent++;
    update_histogram_model(cmd, SAMPLE_W'(value), SEL_W'(sel));
  endtask

  // Hold off the sender until every read result is back and the queue has drained.
  task automatic drain_block();
    start <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_register(input logic [1:0] idx, input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] got;
    case (idx)
      REG_RANGE_MIN: mask = DATA_W'({SAMPLE_W{1'b1}});
      REG_BIN_SCALE: mask = DATA_W'({SCALE_W{1'b1}});
      default:       mask = DATA_W'(1);
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if ((got & mask) !== (want & mask)) begin
      report_mismatch($sformatf("register %0d readback", idx), want & mask, got & mask);
    end
  endtask

  task automatic program_register(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    cfg_writes++;
    case (idx)
      REG_RANGE_MIN: model_min    = value[SAMPLE_W-1:0];
      REG_BIN_SCALE: model_scale  = value[SCALE_W-1:0];
      REG_COUNT_EN:  model_enable = value[0];
      default: ;
    endcase
    check_register(idx, value);
  endtask

  task automatic configure(input int min_value, input logic [SCALE_W-1:0] scale,
                           input logic enable);
    drain_block();
    program_register(REG_RANGE_MIN, DATA_W'(min_value));
    program_register(REG_BIN_SCALE, DATA_W'(scale));
    program_register(REG_COUNT_EN, DATA_W'(enable));
  endtask

  // Compare each read result with the oldest pending read.
  always @(posedge clk) begin
    bin_read_t want;
    if (rst_n && out_valid) begin
      if (pending_reads.size() == 0) begin
        report_mismatch("unexpected result, bin index", 0, out_bin_index);
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (out_bin_count !== want.count) begin
          report_mismatch($sformatf("bin %0d count", want.index), want.count, out_bin_count);
        end
        if (out_bin_index !== want.index) begin
          report_mismatch("bin index", want.index, out_bin_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || psel) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t no progress for %0d cycles, %0d reads outstanding",
                 $time, STALL_LIMIT, pending_reads.size());
        $display("tb_normalized_gray_histogram_core failed");
        $finish;
      end
    end
  end

  // Register reset values; counting is off after reset: samples leave the bins alone.
  task automatic test_after_reset();
    check_register(REG_RANGE_MIN, DATA_W'(RANGE_MIN_RST));
    check_register(REG_BIN_SCALE, DATA_W'(BIN_SCALE_RST));
    check_register(REG_COUNT_EN, '0);
    issue_command(CMD_COUNT, 100, 0);
    issue_command(CMD_READ, 0, 100);
    issue_command(CMD_READ, 0, 0);
  endtask

  task automatic test_bin_mapping();
    configure(0, SCALE_W'(65536), 1'b1);
    issue_command(CMD_COUNT, 0, 0);        // zero difference lands in bin 0
    issue_command(CMD_COUNT, -32768, 0);   // negative difference lands in bin 0
    issue_command(CMD_COUNT, -1, 0);
    issue_command(CMD_COUNT, 32767, 0);    // saturate to the last bin
    issue_command(CMD_COUNT, 255, 0);
    issue_command(CMD_COUNT, 256, 0);
    issue_command(CMD_COUNT, 3, 0);
    issue_command(CMD_COUNT, 1, 0);
    issue_command(CMD_COUNT, 2, 0);
    issue_command(CMD_READ, 0, 0);         // reserved bins read zero
    issue_command(CMD_READ, 0, 1);
    issue_command(CMD_READ, 0, 2);
    issue_command(CMD_READ, 0, 3);
    issue_command(CMD_READ, -1, 255);
    issue_command(CMD_UNUSED, -1, 255);    // unused code: no result
    issue_command(CMD_READ, 0, 254);
    issue_command(CMD_CLEAR, -1, 255);
    issue_command(CMD_READ, 0, 255);
    issue_command(CMD_READ, 0, 3);
  endtask

  task automatic test_range_extremes();
    configure(-32768, '1, 1'b1);
    issue_command(CMD_COUNT, 32767, 0);
    issue_command(CMD_COUNT, -32767, 0);   // smallest positive difference, largest scale
    issue_command(CMD_READ, 0, 255);
    configure(32767, '0, 1'b1);
    issue_command(CMD_COUNT, -32768, 0);
    issue_command(CMD_COUNT, 32767, 0);
    issue_command(CMD_READ, 0, 0);
  endtask

  task automatic test_counting_disabled();
    configure(0, SCALE_W'(65536), 1'b0);
    issue_command(CMD_COUNT, 50, 0);
    issue_command(CMD_READ, 0, 50);
  endtask

  // One frame setting followed by a burst of mostly well-formed traffic.
  task automatic run_random_segment(input int seg_id);
    int                 lo;
    int                 span;
    int                 roll;
    logic [SCALE_W-1:0] scale;
    logic               enable;
    lo   = int'($urandom_range(65535)) - 32768;
    span = $urandom_range(32767 - lo, 0);
    if ($urandom_range(1) && span > 600) span = $urandom_range(600, 1);
    case (seg_id)
      1:       begin lo = -32768; span = 65535; end
      7:       begin lo = 32767;  span = 0; end
      default: ;
    endcase
    enable = (span != 0);
    scale  = (span != 0) ? SCALE_W'((255 * 65536) / span) : BIN_SCALE_RST;
    case (seg_id)
      3:       scale = '1;
      5:       scale = '0;
      7:       enable = 1'b1;
      9:       enable = 1'b0;
      default: ;
    endcase
    configure(lo, scale, enable);
    if ($urandom_range(1)) issue_command(CMD_CLEAR, 0, 0);
    for (int n = 0; n < SEGMENT_ITEMS; n++) begin
      roll = $urandom_range(99);
      if (roll < 58) begin
        issue_command(CMD_COUNT, lo + int'($urandom_range(span)), $urandom_range(255));
      end else if (roll < 63) begin
        issue_command(CMD_COUNT, int'($urandom_range(65535)) - 32768, $urandom_range(255));
      end else if (roll < 94) begin
        issue_command(CMD_READ, int'($urandom_range(65535)) - 32768, $urandom_range(255));
      end else if (roll < 96) begin
        issue_command(CMD_CLEAR, int'($urandom_range(65535)) - 32768, $urandom_range(255));
      end else begin
        issue_command(CMD_UNUSED, int'($urandom_range(65535)) - 32768, $urandom_range(255));
      end
    end
  endtask

  task automatic test_random_traffic();
    int profiles [3] = '{36, 80, 0};
    for (int p = 0; p < 3; p++) begin
      idle_pct = profiles[p];
      for (int s = 0; s < 4; s++) run_random_segment(4 * p + s);
    end
  endtask

  initial begin
    clear_model_bins();
    idle_pct = 36;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_bin_mapping();
    test_range_extremes();
    test_counting_disabled();
    test_random_traffic();
    drain_block();
    $display("covered %0d command items, %0d bin reads checked, %0d register writes",
             items_sent, reads_checked, cfg_writes);
    $display("sender idle profiles 36/80/0 percent, range and scale extremes included");
    if (fail_count == 0) begin
      $display("tb_normalized_gray_histogram_core passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb_normalized_gray_histogram_core failed");
    end
    $finish;
  end

endmodule
